### hw/rtl/table_interpolator_defines.svh
// Assertion macros for the table interpolator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TABLE_INTERPOLATOR_DEFINES_SVH
`define TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("table_interpolator: same-cycle check failed");
// Next-cycle implication.
`define TI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("table_interpolator: next-cycle check failed");
`else
`define TI_ASSERT_IMP(name, ante, cons)
`define TI_ASSERT_NXT(name, ante, cons)
`endif
`endif

### hw/rtl/tinterp_pkg.sv
package tinterp_pkg;

  // Field and datapath widths.
  localparam int DATA_W         = 32;
  localparam int DEF_MAX_POINTS = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;
  localparam int PC_W           = 5;
  localparam int SLOT_W         = 4;
  localparam int IN_DATA_W      = 72;
  localparam int PROD_W         = 96;
  localparam int DEN_W          = 64;
  localparam int QUOT_LIMIT     = 40;
  localparam int INV_ONE_BIT    = 62;
  localparam int DIV_CNT_W      = 7;
  localparam int DY_W           = 33;
  localparam int SUM_W          = 43;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_INTERP_MODE = 1'b1
  } cfg_reg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_NEXT,
    OP_TAKE_HI,
    OP_TAKE_LO,
    OP_TAKE_CLAMP,
    OP_SET_Y0,
    OP_FAULT,
    OP_SQUARE,
    OP_DIV_INV,
    OP_INV_STORE,
    OP_BLEND_SET,
    OP_MUL_STEP,
    OP_DIV_BLEND,
    OP_FINISH
  } dp_op_t;

  // Which abscissa an inverse-square step works on.
  typedef enum logic [1:0] {
    SEL_X0,
    SEL_X1,
    SEL_QX
  } sel_t;

  typedef struct packed {
    dp_op_t op;
    sel_t   sel;
    logic   rd_prev;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic greater;
    logic idx_last;
    logic idx_zero;
    logic count_one;
    logic is_load;
    logic mode;
    logic x_equal;
    logic any_zero;
    logic inv_equal;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/tinterp_div.sv
module tinterp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tinterp_pkg::PROD_W-1:0] dividend,
  input  logic [tinterp_pkg::DEN_W-1:0]  divisor,
  output logic [tinterp_pkg::PROD_W-1:0] quot,
  output logic                         done
);
  import tinterp_pkg::*;

  logic [PROD_W-1:0]    dvd;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W-1:0]     trial;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem[DEN_W-2:0], dvd[PROD_W-1]};
  assign fits  = (trial >= den);

  // Iteration counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[PROD_W-2:0], 1'b0};
      rem  <= fits ? trial - den : trial;
      quot <= {quot[PROD_W-2:0], fits};
    end
  end

endmodule

### hw/rtl/tinterp_dp.sv
module tinterp_dp #(
  parameter int MAX_POINTS = tinterp_pkg::DEF_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tinterp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tinterp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tinterp_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tinterp_pkg::DATA_W-1:0]    m_tdata,
  output logic [0:0]                        m_tuser,
  input  tinterp_pkg::dp_cmd_t              cmd,
  output tinterp_pkg::dp_stat_t             stat
);
  import tinterp_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (CW > PC_W) ? CW : PC_W;

  // Configuration registers.
  logic [PC_W-1:0] point_count;
  logic            interp_mode;

  // Breakpoint memories and their registered read data.
  logic [DATA_W-1:0] x_mem [MAX_POINTS];
  logic [DATA_W-1:0] y_mem [MAX_POINTS];
  logic [DATA_W-1:0] rd_x;
  logic [DATA_W-1:0] rd_y;
  logic [AW-1:0]     rd_addr;

  // Item and working registers.
  logic              is_load;
  logic [DATA_W-1:0] qx, x0, x1, y0, y1;
  logic [AW-1:0]     idx;
  logic [DEN_W-1:0]  sq;
  logic [DEN_W-1:0]  inv_x0, inv_x1, inv_qx;
  logic [PROD_W-1:0] mcand;
  logic [DY_W-1:0]   mplier;
  logic [PROD_W-1:0] acc;
  logic [DEN_W-1:0]  den_mag;
  logic              neg;
  logic [DATA_W-1:0] res_value;
  logic              res_status;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_status;

  // Input fields.
  logic              in_cmd;
  logic [SLOT_W-1:0] in_slot;
  logic [DATA_W-1:0] in_x, in_y;
  assign in_cmd  = s_tuser[0];
  assign in_slot = s_tdata[3:0];
  assign in_x    = s_tdata[35:4];
  assign in_y    = s_tdata[67:36];

  // Effective point count, clamped to one through the table depth.
  logic [CMPW-1:0] pc_ext;
  logic [CW-1:0]   count;
  logic            slot_ok;
  assign pc_ext  = CMPW'(point_count);
  assign slot_ok = (CMPW'(in_slot) < CMPW'(MAX_POINTS));
  always_comb begin
    if (pc_ext == '0) begin
      count = CW'(1);
    end else if (pc_ext > CMPW'(MAX_POINTS)) begin
      count = CW'(MAX_POINTS);
    end else begin
      count = CW'(pc_ext);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_W'(1);
      interp_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POINT_COUNT: point_count <= cfg_data;
        REG_INTERP_MODE: interp_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memory: one write port for loads, one registered read port.
  assign rd_addr = cmd.rd_prev ? idx - AW'(1) : idx;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE && !in_cmd && slot_ok) begin
      x_mem[AW'(in_slot)] <= in_x;
      y_mem[AW'(in_slot)] <= in_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  // Magnitude of the abscissa chosen for squaring.
  logic [DATA_W-1:0] sq_src, sq_mag;
  logic [DEN_W-1:0]  sq_full;
  always_comb begin
    case (cmd.sel)
      SEL_X0:  sq_src = x0;
      SEL_X1:  sq_src = x1;
      default: sq_src = qx;
    endcase
  end
  assign sq_mag  = sq_src[DATA_W-1] ? DATA_W'(0) - sq_src : sq_src;
  assign sq_full = DEN_W'(sq_mag) * DEN_W'(sq_mag);

  // Blend operands: dy * num / den, with signs split off.
  logic [DY_W-1:0]  dy, dy_mag, num0, den0;
  logic [DEN_W-1:0] num, den, num_mag, den_abs;
  assign dy   = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};
  assign num0 = {qx[DATA_W-1], qx} - {x0[DATA_W-1], x0};
  assign den0 = {x1[DATA_W-1], x1} - {x0[DATA_W-1], x0};
  assign num  = interp_mode ? inv_qx - inv_x0 : {{(DEN_W-DY_W){num0[DY_W-1]}}, num0};
  assign den  = interp_mode ? inv_x1 - inv_x0 : {{(DEN_W-DY_W){den0[DY_W-1]}}, den0};
  assign dy_mag  = dy[DY_W-1] ? DY_W'(0) - dy : dy;
  assign num_mag = num[DEN_W-1] ? DEN_W'(0) - num : num;
  assign den_abs = den[DEN_W-1] ? DEN_W'(0) - den : den;

  // Shared divider for the inverse squares and the blend.
  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic [PROD_W-1:0] quot;
  logic              div_done;
  assign div_start    = (cmd.op == OP_DIV_INV) || (cmd.op == OP_DIV_BLEND);
  assign div_dividend = (cmd.op == OP_DIV_INV) ? (PROD_W'(1) << INV_ONE_BIT) : acc;
  assign div_divisor  = (cmd.op == OP_DIV_INV) ? sq : den_mag;

  tinterp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (quot),
    .done     (div_done)
  );

  // Final add of the clamped quotient to y0, saturated to 32 bits.
  logic                    big;
  logic [QUOT_LIMIT:0]     qv;
  logic signed [SUM_W-1:0] y0_ext, q_ext, sum;
  logic [DATA_W-1:0]       sat_value;
  assign big    = |quot[PROD_W-1:QUOT_LIMIT];
  assign qv     = big ? ((QUOT_LIMIT+1)'(1) << QUOT_LIMIT) : {1'b0, quot[QUOT_LIMIT-1:0]};
  assign y0_ext = {{(SUM_W-DATA_W){y0[DATA_W-1]}}, y0};
  assign q_ext  = {{(SUM_W-QUOT_LIMIT-1){1'b0}}, qv};
  assign sum    = neg ? y0_ext - q_ext : y0_ext + q_ext;
  always_comb begin
    if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
      sat_value = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Working registers, stepped by the controller's operation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        is_load    <= !in_cmd;
        qx         <= in_x;
        idx        <= '0;
        res_value  <= '0;
        res_status <= 1'b0;
      end
      OP_NEXT:       idx <= idx + AW'(1);
      OP_TAKE_HI: begin
        x1 <= rd_x;
        y1 <= rd_y;
      end
      OP_TAKE_LO: begin
        x0 <= rd_x;
        y0 <= rd_y;
      end
      OP_TAKE_CLAMP: res_value  <= rd_y;
      OP_SET_Y0:     res_value  <= y0;
      OP_FAULT:      res_status <= 1'b1;
      OP_SQUARE:     sq <= sq_full;
      OP_INV_STORE: begin
        case (cmd.sel)
          SEL_X0:  inv_x0 <= quot[DEN_W-1:0];
          SEL_X1:  inv_x1 <= quot[DEN_W-1:0];
          default: inv_qx <= quot[DEN_W-1:0];
        endcase
      end
      OP_BLEND_SET: begin
        mcand   <= PROD_W'(num_mag);
        mplier  <= dy_mag;
        acc     <= '0;
        den_mag <= den_abs;
        neg     <= dy[DY_W-1] ^ num[DEN_W-1] ^ den[DEN_W-1];
      end
      OP_MUL_STEP: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[DY_W-1:1]};
      end
      OP_FINISH:     res_value <= sat_value;
      default: ;
    endcase
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_value;
  assign m_tuser[0] = out_status;

  // Status toward the controller.
  assign stat.greater   = ($signed(qx) > $signed(rd_x));
  assign stat.idx_last  = (CW'(idx) == count - CW'(1));
  assign stat.idx_zero  = (idx == '0);
  assign stat.count_one = (count == CW'(1));
  assign stat.is_load   = is_load;
  assign stat.mode      = interp_mode;
  assign stat.x_equal   = (x1 == x0);
  assign stat.any_zero  = (x0 == '0) || (x1 == '0) || (qx == '0);
  assign stat.inv_equal = (inv_x1 == inv_x0);
  assign stat.mul_done  = (mplier == '0);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || m_tready;

endmodule

### hw/rtl/tinterp_ctrl.sv
module tinterp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  tinterp_pkg::dp_stat_t stat,
  output tinterp_pkg::dp_cmd_t  cmd
);
  import tinterp_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_START    = 15'b000000000000010,
    ST_CLAMP    = 15'b000000000000100,
    ST_SCAN_RD  = 15'b000000000001000,
    ST_SCAN_CMP = 15'b000000000010000,
    ST_FETCH_LO = 15'b000000000100000,
    ST_DECIDE   = 15'b000000001000000,
    ST_SQUARE   = 15'b000000010000000,
    ST_INV_GO   = 15'b000000100000000,
    ST_INV_WAIT = 15'b000001000000000,
    ST_INV_CHK  = 15'b000010000000000,
    ST_BL_SET   = 15'b000100000000000,
    ST_MUL      = 15'b001000000000000,
    ST_BL_WAIT  = 15'b010000000000000,
    ST_DONE     = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  sel_t   sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= SEL_X0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Sequencing of one item: a load goes straight to done; a query scans, fetches neighbors, then clamps or blends.
  always_comb begin
    state_next   = state;
    sel_next     = sel;
    cmd.op       = OP_NONE;
    cmd.sel      = sel;
    cmd.rd_prev  = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.is_load) begin
          state_next = ST_DONE;
        end else if (stat.count_one) begin
          state_next = ST_CLAMP;
        end else begin
          state_next = ST_SCAN_CMP;
        end
      end
      ST_CLAMP: begin
        cmd.op     = OP_TAKE_CLAMP;
        state_next = ST_DONE;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (stat.greater && stat.idx_last) begin
          // Above the last breakpoint.
          cmd.op     = OP_TAKE_CLAMP;
          state_next = ST_DONE;
        end else if (stat.greater) begin
          cmd.op     = OP_NEXT;
          state_next = ST_SCAN_RD;
        end else if (stat.idx_zero) begin
          // At or below the first breakpoint.
          cmd.op     = OP_TAKE_CLAMP;
          state_next = ST_DONE;
        end else begin
          cmd.op      = OP_TAKE_HI;
          cmd.rd_prev = 1'b1;
          state_next  = ST_FETCH_LO;
        end
      end
      ST_FETCH_LO: begin
        cmd.op     = OP_TAKE_LO;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.mode && stat.x_equal) begin
          cmd.op     = OP_SET_Y0;
          state_next = ST_DONE;
        end else if (!stat.mode) begin
          state_next = ST_BL_SET;
        end else if (stat.any_zero) begin
          cmd.op     = OP_FAULT;
          state_next = ST_DONE;
        end else begin
          sel_next   = SEL_X0;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.op     = OP_SQUARE;
        state_next = ST_INV_GO;
      end
      ST_INV_GO: begin
        cmd.op     = OP_DIV_INV;
        state_next = ST_INV_WAIT;
      end
      ST_INV_WAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_INV_STORE;
          case (sel)
            SEL_X0: begin
              sel_next   = SEL_X1;
              state_next = ST_SQUARE;
            end
            SEL_X1: begin
              sel_next   = SEL_QX;
              state_next = ST_SQUARE;
            end
            default: state_next = ST_INV_CHK;
          endcase
        end
      end
      ST_INV_CHK: begin
        if (stat.inv_equal) begin
          cmd.op     = OP_FAULT;
          state_next = ST_DONE;
        end else begin
          state_next = ST_BL_SET;
        end
      end
      ST_BL_SET: begin
        cmd.op     = OP_BLEND_SET;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (stat.mul_done) begin
          cmd.op     = OP_DIV_BLEND;
          state_next = ST_BL_WAIT;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_BL_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_FINISH;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/table_interpolator.sv
// One item at a time; the input reopens in the cycle after a result is loaded.
// A load goes from the start state straight to the done state. A linear query
// scans the breakpoints up to index i, takes s <= 33 multiply steps and one pass
// through the 96-step divider. Inverse-square mode adds three square-and-divide
// passes and a check. Synchronous reset sets point_count to 1 and interp_mode to 0.
`include "table_interpolator_defines.svh"

module table_interpolator #(
  parameter int MAX_POINTS = tinterp_pkg::DEF_MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tinterp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tinterp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata: slot[3:0], arg_x[35:4], arg_y[67:36], zero fill[71:68]
  input  logic [tinterp_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: cmd[0]
  input  logic [0:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: value_y[31:0]
  output logic [tinterp_pkg::DATA_W-1:0]     m_tdata,
  // m_tuser: status[0]
  output logic [0:0]                         m_tuser
);
  import tinterp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tinterp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tinterp_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

  // An accepted item keeps the input closed for at least the next cycle.
  `TI_ASSERT_NXT(a_accept_closes, s_tvalid && s_tready, !s_tready)
  // A result is only loaded when the output register can take it.
  `TI_ASSERT_IMP(a_load_when_free, cmd.out_load, stat.out_free)
  // A faulted result always carries a zero value.
  `TI_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule
